// ----- sv/pd_with_sine_feedforward_core_defines.svh -----
// assertion macros shared by the pd controller rtl
`ifndef PD_WITH_SINE_FEEDFORWARD_CORE_DEFINES_SVH
`define PD_WITH_SINE_FEEDFORWARD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define PDFF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdff assertion failed");
// next-cycle implication, checked at every rising edge outside reset
`define PDFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdff assertion failed");
`else
`define PDFF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PDFF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/pdff_pkg.sv -----
// shared types, constants and the sine table generator of the pd controller
package pdff_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 16;

  localparam int GAIN_W = 16;
  localparam int POS_W  = 16;
  localparam int TICK_W = 32;
  localparam int CMD_W  = 24;
  localparam int SINE_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
  localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_DERIV_GAIN   = 3'd1,
    CFG_TARGET_POS   = 3'd2,
    CFG_WAVE_GAIN    = 3'd3,
    CFG_PHASE_STEP   = 3'd4,
    CFG_PHASE_OFFSET = 3'd5,
    CFG_FB_ENABLE    = 3'd6,
    CFG_FF_ENABLE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic signed [POS_W-1:0]  target_position;
    logic [GAIN_W-1:0]        wave_gain;
    logic [15:0]              phase_step;
    logic [15:0]              phase_offset;
    logic                     feedback_enable;
    logic                     feedforward_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:          16'd25600,
    deriv_gain:         16'd3840,
    target_position:    16'sd0,
    wave_gain:          16'd3840,
    phase_step:         16'd66,
    phase_offset:       16'd0,
    feedback_enable:    1'b1,
    feedforward_enable: 1'b0
  };

  // one sine table entry, round(32767*sin(2*pi*idx/2^tbits)), quarter-wave
  // symmetry and a q30 taylor series evaluated from the highest term down
  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                         input int unsigned tbits);
    longint unsigned n;
    longint unsigned i;
    longint unsigned q;
    longint unsigned r;
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned p;
    longint unsigned s;
    longint unsigned m;
    n = 64'd1 << tbits;
    i = longint'(idx) & (n - 64'd1);
    q = i >> (tbits - 2);
    r = i & ((64'd1 << (tbits - 2)) - 64'd1);
    a = q[0] ? (64'd1 << (tbits - 2)) - r : r;
    x = (a * HALF_PI_Q30) >> (tbits - 2);
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    p = ((x2 * t) >> 30) / 210;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p = ((x2 * t) >> 30) / 156;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p = ((x2 * t) >> 30) / 110;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p = ((x2 * t) >> 30) / 72;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p = ((x2 * t) >> 30) / 42;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p = ((x2 * t) >> 30) / 20;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    p = ((x2 * t) >> 30) / 6;
    t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    s = (x * t) >> 30;
    m = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    if (q >= 64'd2) begin
      return -$signed(SINE_W'(m));
    end
    return $signed(SINE_W'(m));
  endfunction

endpackage

// ----- sv/pdff_in_if.sv -----
// sample channel: joint position, velocity and tick count
interface pdff_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pdff_pkg::POS_W-1:0]      position;
  logic signed [pdff_pkg::POS_W-1:0]      velocity;
  logic        [pdff_pkg::TICK_W-1:0]     tick_count;

  modport source(output valid, output position, output velocity, output tick_count,
                 input ready);
  modport sink(input valid, input position, input velocity, input tick_count,
               output ready);
endinterface

// ----- sv/pdff_out_if.sv -----
// result channel: saturated motor command and its clip flag
interface pdff_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pdff_pkg::CMD_W-1:0]  command;
  logic                               saturated;

  modport source(output valid, output command, output saturated, input ready);
  modport sink(input valid, input command, input saturated, output ready);
endinterface

// ----- sv/pdff_cfg_regs.sv -----
// configuration register file of the pd controller
module pdff_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pdff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdff_pkg::GAIN_W-1:0]         cfg_wdata,
  output pdff_pkg::cfg_t                      cfg
);

  pdff_pkg::cfg_t cfg_r;
  pdff_pkg::cfg_t cfg_nxt;

  // decode one write into the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (pdff_pkg::cfg_idx_t'(cfg_index))
        pdff_pkg::CFG_PROP_GAIN:    cfg_nxt.prop_gain          = cfg_wdata;
        pdff_pkg::CFG_DERIV_GAIN:   cfg_nxt.deriv_gain         = cfg_wdata;
        pdff_pkg::CFG_TARGET_POS:   cfg_nxt.target_position    = $signed(cfg_wdata);
        pdff_pkg::CFG_WAVE_GAIN:    cfg_nxt.wave_gain          = cfg_wdata;
        pdff_pkg::CFG_PHASE_STEP:   cfg_nxt.phase_step         = cfg_wdata;
        pdff_pkg::CFG_PHASE_OFFSET: cfg_nxt.phase_offset       = cfg_wdata;
        pdff_pkg::CFG_FB_ENABLE:    cfg_nxt.feedback_enable    = cfg_wdata[0];
        pdff_pkg::CFG_FF_ENABLE:    cfg_nxt.feedforward_enable = cfg_wdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  // register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pdff_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/pdff_sine_rom.sv -----
// constant sine table with registered read port
module pdff_sine_rom #(
  parameter int SINE_TABLE_BITS = pdff_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [SINE_TABLE_BITS-1:0]           rd_addr,
  output logic signed [pdff_pkg::SINE_W-1:0]   rd_data
);

  localparam int ROM_DEPTH = 1 << SINE_TABLE_BITS;

  logic signed [pdff_pkg::SINE_W-1:0] rom_w [ROM_DEPTH];
  logic signed [pdff_pkg::SINE_W-1:0] data_r;

  // table contents fixed at elaboration
  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
    assign rom_w[gi] = pdff_pkg::sine_entry(gi, SINE_TABLE_BITS);
  end

  // registered read, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= rom_w[rd_addr];
    end
  end

  assign rd_data = data_r;

endmodule

// ----- sv/pd_with_sine_feedforward_core.sv -----
// top level: five-stage pd controller with sine feedforward
//
// usage
// - in_chan carries one sample (position, velocity, tick_count) per request;
//   out_chan returns one result (command, saturated) per sample, in order.
// - registers are written through cfg_wr_en / cfg_index / cfg_wdata, one per
//   cycle, while no sample is in flight; unknown bits above a field's width
//   are dropped.
// - a sample passes through the five register stages in order (multipliers,
//   feedback sum and phase add, sine table read, feedforward multiply, round
//   and saturate), each with its own valid bit; out_chan.valid rises once the
//   result sits in the last stage. throughput is one sample per cycle while
//   out_chan.ready is high.
// - when out_chan.ready is low the last stage holds its result and earlier
//   stages keep filling empty slots, so in_chan.ready only drops once all
//   five stages hold a sample.
// - a synchronous low rst_n empties the pipeline and loads the register
//   reset values: all gains and phase settings at their defaults, feedback
//   on, feedforward off.
`include "pd_with_sine_feedforward_core_defines.svh"

module pd_with_sine_feedforward_core #(
  parameter int SINE_TABLE_BITS = pdff_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = pdff_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pdff_in_if.sink                           in_chan,
  pdff_out_if.source                        out_chan,
  input  logic                              cfg_wr_en,
  input  logic [pdff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdff_pkg::GAIN_W-1:0]       cfg_wdata
);

  localparam int NSTG   = 5;
  localparam int PE_W   = 34;
  localparam int DV_W   = 33;
  localparam int FB_W   = 35;
  localparam int FF_W   = 33;
  localparam int ACC_W  = 39;
  localparam int RND_W  = ACC_W - 11;
  localparam int CMD_W  = pdff_pkg::CMD_W;
  localparam int PROD_W = pdff_pkg::TICK_W + 16;

  pdff_pkg::cfg_t cfg;

  logic [NSTG:1] v_r;
  logic [NSTG:1] v_nxt;
  logic [NSTG:1] rdy;

  logic signed [PE_W-1:0]            pe_r;
  logic signed [DV_W-1:0]            dv_r;
  logic [PHASE_BITS-1:0]             ph_prod_r;
  logic signed [FB_W-1:0]            fb2_r;
  logic signed [FB_W-1:0]            fb3_r;
  logic signed [FB_W-1:0]            fb4_r;
  logic [SINE_TABLE_BITS-1:0]        addr_r;
  logic signed [pdff_pkg::SINE_W-1:0] sine_w;
  logic signed [FF_W-1:0]            ff_r;
  logic signed [CMD_W-1:0]           cmd_r;
  logic                              sat_r;

  logic signed [16:0]                err_w;
  logic [PROD_W-1:0]                 ph_full_w;
  logic [PHASE_BITS+15:0]            ph_sum_w;
  logic [PHASE_BITS-1:0]             phase_w;
  logic [SINE_TABLE_BITS-1:0]        addr_w;
  logic signed [ACC_W-1:0]           fb_term_w;
  logic signed [ACC_W-1:0]           ff_term_w;
  logic signed [ACC_W-1:0]           acc_w;
  logic signed [RND_W-1:0]           rnd_w;
  logic                              ovf_w;
  logic signed [CMD_W-1:0]           cmd_w;
  logic                              cmd_at_limit_w;

  pdff_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage ready chain: a slot takes new data when empty or moving on
  always_comb begin
    rdy[NSTG] = !v_r[NSTG] || out_chan.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // valid bits move with the data
  always_comb begin
    v_nxt = v_r;
    if (rdy[1]) begin
      v_nxt[1] = in_chan.valid;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: position error and the three products
  assign err_w = $signed({cfg.target_position[15], cfg.target_position})
               - $signed({in_chan.position[15], in_chan.position});
  assign ph_full_w = in_chan.tick_count * cfg.phase_step;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pe_r      <= $signed({1'b0, cfg.prop_gain}) * err_w;
      dv_r      <= $signed({1'b0, cfg.deriv_gain}) * in_chan.velocity;
      ph_prod_r <= ph_full_w[PHASE_BITS-1:0];
    end
  end

  // stage 2: feedback sum and phase wrap into a table address
  assign ph_sum_w = {16'd0, ph_prod_r} + {PHASE_BITS'(0), cfg.phase_offset};
  assign phase_w  = ph_sum_w[PHASE_BITS-1:0];

  if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_addr_top
    assign addr_w = phase_w[PHASE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_addr_shift
    assign addr_w = {phase_w, (SINE_TABLE_BITS - PHASE_BITS)'(0)};
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      fb2_r  <= FB_W'(pe_r) + FB_W'(dv_r);
      addr_r <= addr_w;
    end
  end

  // stage 3: sine table read
  pdff_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rdy[3]),
    .rd_addr (addr_r),
    .rd_data (sine_w)
  );

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      fb3_r <= fb2_r;
    end
  end

  // stage 4: feedforward product
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      fb4_r <= fb3_r;
      ff_r  <= $signed({1'b0, cfg.wave_gain}) * sine_w;
    end
  end

  // stage 5: gate terms, round half up to q12.12 and saturate
  assign fb_term_w = cfg.feedback_enable ? ACC_W'($signed({fb4_r, 3'b000})) : '0;
  assign ff_term_w = cfg.feedforward_enable ? ACC_W'(ff_r) : '0;
  assign acc_w     = fb_term_w + ff_term_w + ACC_W'(1024);
  assign rnd_w     = $signed(acc_w[ACC_W-1:11]);
  assign ovf_w     = rnd_w[RND_W-1:CMD_W-1] != {(RND_W - CMD_W + 1){rnd_w[CMD_W-1]}};

  always_comb begin
    if (!ovf_w) begin
      cmd_w = rnd_w[CMD_W-1:0];
    end else if (rnd_w[RND_W-1]) begin
      cmd_w = pdff_pkg::CMD_MIN;
    end else begin
      cmd_w = pdff_pkg::CMD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      cmd_r <= cmd_w;
      sat_r <= ovf_w;
    end
  end

  assign in_chan.ready     = rdy[1];
  assign out_chan.valid    = v_r[NSTG];
  assign out_chan.command  = cmd_r;
  assign out_chan.saturated = sat_r;

  // held command sits at one of the range limits
  assign cmd_at_limit_w = (cmd_r == pdff_pkg::CMD_MAX) || (cmd_r == pdff_pkg::CMD_MIN);

  // a clip flag only comes with a command at one of the limits
  `PDFF_ASSERT_IMPL(a_sat_at_limit, clk, rst_n, v_r[NSTG] && sat_r, cmd_at_limit_w)
  // an accepted sample occupies the first stage next cycle
  `PDFF_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_chan.valid && in_chan.ready, v_r[1])
  // a blocked middle stage keeps its sample
  `PDFF_ASSERT_NEXT(a_stall_holds, clk, rst_n, v_r[2] && !rdy[3], v_r[2])
  // a waiting result keeps the last slot full
  `PDFF_ASSERT_NEXT(a_out_kept, clk, rst_n, v_r[NSTG] && !out_chan.ready, v_r[NSTG])

endmodule
